### rtl/usbcrr_pkg.sv
// Package for the endpoint-zero control request responder.
// Holds the port word types, request codes, the queued command type and the descriptor ROMs.
// No dependencies.
`default_nettype none

package usbcrr_pkg;

    // Input word: one received setup packet plus its operands
    typedef struct packed {
        logic [31:0] request_word0;
        logic [31:0] request_word1;
        logic [31:0] payload_word_a;
        logic [31:0] payload_word_b;
        logic [31:0] payload_word_c;
        logic [31:0] payload_word_d;
        logic [7:0]  storage_state_byte;
        logic [7:0]  command_block_count;
        logic [31:0] receive_status_word;
    } t_req;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_ZLP  = 2'd1,
        KIND_ACK  = 2'd2,
        KIND_NONE = 2'd3
    } t_reply_kind;

    // Output word: one reply result
    typedef struct packed {
        t_reply_kind reply_kind;
        logic [7:0]  reply_byte;
        logic        last_of_reply;
        logic [6:0]  device_address;
        logic        is_configured;
    } t_rsp;

    // Decoded request classes
    typedef enum logic [3:0] {
        OP_DEV_DESC  = 4'd0,
        OP_SET_ADDR  = 4'd1,
        OP_CFG_DESC  = 4'd2,
        OP_LANG_DESC = 4'd3,
        OP_STR_DESC  = 4'd4,
        OP_SET_CFG   = 4'd5,
        OP_VEND_ZERO = 4'd6,
        OP_KEY_UPD   = 4'd7,
        OP_STATUS    = 4'd8,
        OP_OK        = 4'd9,
        OP_ZLP       = 4'd10,
        OP_UNKNOWN   = 4'd11
    } t_op;

    localparam int LEN_W = 6;

    // Classified command passed from front to back
    typedef struct packed {
        t_op              op;
        logic [LEN_W-1:0] len;        // number of results, never zero
        logic             ok_three;   // tagged reply carries 0x03 rather than 0x02
        logic             key_set;    // key update targets set 1
        logic [6:0]       addr;
        logic [3:0][31:0] keys;
        logic [7:0]       storage;
        logic [7:0]       cbw;
        logic [31:0]      rx_status;
    } t_cmd;

    // Request codes (first setup word)
    localparam logic [31:0] REQ_GET_DEV_DESC  = 32'h8006_0001;
    localparam logic [15:0] REQ_SET_ADDR_HI   = 16'h0005;
    localparam logic [31:0] REQ_GET_CFG_DESC  = 32'h8006_0002;
    localparam logic [31:0] REQ_GET_LANG_DESC = 32'h8006_0003;
    localparam logic [31:0] REQ_GET_STR_A     = 32'h8006_0303;
    localparam logic [31:0] REQ_GET_STR_B     = 32'h8006_0203;
    localparam logic [15:0] REQ_SET_CFG_HI    = 16'h0009;
    localparam logic [31:0] REQ_VEND_ZERO     = 32'hA1FE_0000;
    localparam logic [31:0] REQ_KEY_UPD       = 32'h0A0B_0C0D;
    localparam logic [31:0] REQ_STATUS        = 32'hC001_0000;
    localparam logic [31:0] REQ_OK_TWO        = 32'hC002_0000;
    localparam logic [31:0] REQ_OK_THREE      = 32'hC003_0000;

    // Reply lengths
    localparam logic [LEN_W-1:0] DEV_DESC_LEN  = 6'd18;
    localparam logic [LEN_W-1:0] CFG_DESC_LEN  = 6'd32;
    localparam logic [LEN_W-1:0] LANG_DESC_LEN = 6'd4;
    localparam logic [LEN_W-1:0] STR_DESC_LEN  = 6'd22;
    localparam logic [LEN_W-1:0] STATUS_LEN    = 6'd51;
    localparam logic [LEN_W-1:0] OK_LEN        = 6'd4;
    localparam logic [LEN_W-1:0] SINGLE_LEN    = 6'd1;

    // Status dump layout
    localparam logic [LEN_W-1:0] STAT_TAG_END  = 6'd12;
    localparam logic [LEN_W-1:0] STAT_KEY_BASE = 6'd13;
    localparam logic [LEN_W-1:0] STAT_KEY_END  = 6'd44;
    localparam logic [LEN_W-1:0] STAT_STORAGE  = 6'd45;
    localparam logic [LEN_W-1:0] STAT_CBW      = 6'd46;
    localparam logic [LEN_W-1:0] STAT_RX_BASE  = 6'd47;

    localparam logic [7:0] STATUS_HDR = 8'hFA;
    localparam logic [7:0] OK_HDR     = 8'hFB;
    localparam logic [7:0] OK_TWO     = 8'h02;
    localparam logic [7:0] OK_THREE   = 8'h03;
    localparam logic [7:0] OK_CHAR_O  = 8'h4F;
    localparam logic [7:0] OK_CHAR_K  = 8'h6B;

    // Byte count clamped to a descriptor size
    function automatic logic [LEN_W-1:0] clamp_len(input logic [7:0] want,
                                                   input logic [LEN_W-1:0] size);
        if (want > {2'b00, size}) begin
            return size;
        end
        return want[LEN_W-1:0];
    endfunction

    // Big-endian byte of a word
    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] dev_rom(input logic [4:0] i);
        logic [7:0] b;
        case (i)
            5'd0:  b = 8'h12;  5'd1:  b = 8'h01;  5'd2:  b = 8'h00;  5'd3:  b = 8'h02;
            5'd4:  b = 8'h00;  5'd5:  b = 8'h00;  5'd6:  b = 8'h00;  5'd7:  b = 8'h40;
            5'd8:  b = 8'h09;  5'd9:  b = 8'h23;  5'd10: b = 8'h06;  5'd11: b = 8'h06;
            5'd12: b = 8'h01;  5'd13: b = 8'h00;  5'd14: b = 8'h01;  5'd15: b = 8'h02;
            5'd16: b = 8'h03;  5'd17: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] cfg_rom(input logic [4:0] i);
        logic [7:0] b;
        case (i)
            5'd0:  b = 8'h09;  5'd1:  b = 8'h02;  5'd2:  b = 8'h20;  5'd3:  b = 8'h00;
            5'd4:  b = 8'h01;  5'd5:  b = 8'h01;  5'd6:  b = 8'h00;  5'd7:  b = 8'h80;
            5'd8:  b = 8'hfa;  5'd9:  b = 8'h09;  5'd10: b = 8'h04;  5'd11: b = 8'h00;
            5'd12: b = 8'h00;  5'd13: b = 8'h02;  5'd14: b = 8'h08;  5'd15: b = 8'h06;
            5'd16: b = 8'h50;  5'd17: b = 8'h00;  5'd18: b = 8'h07;  5'd19: b = 8'h05;
            5'd20: b = 8'h01;  5'd21: b = 8'h02;  5'd22: b = 8'h00;  5'd23: b = 8'h02;
            5'd24: b = 8'h00;  5'd25: b = 8'h07;  5'd26: b = 8'h05;  5'd27: b = 8'h82;
            5'd28: b = 8'h02;  5'd29: b = 8'h00;  5'd30: b = 8'h02;  default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] lang_rom(input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = 8'h04;
            2'd1:    b = 8'h03;
            2'd2:    b = 8'h09;
            default: b = 8'h04;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] str_rom(input logic [4:0] i);
        logic [7:0] b;
        case (i)
            5'd0:  b = 8'h16;  5'd1:  b = 8'h03;  5'd2:  b = 8'h48;  5'd4:  b = 8'h4C;
            5'd6:  b = 8'h4A;  5'd8:  b = 8'h55;  5'd10: b = 8'h20;  5'd12: b = 8'h55;
            5'd14: b = 8'h44;  5'd16: b = 8'h49;  5'd18: b = 8'h53;  5'd20: b = 8'h4B;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tag_rom(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:  b = 8'h51;  4'd1:  b = 8'h51;  4'd2:  b = 8'h3A;  4'd3:  b = 8'h32;
            4'd4:  b = 8'h34;  4'd5:  b = 8'h33;  4'd6:  b = 8'h36;  4'd7:  b = 8'h30;
            4'd8:  b = 8'h37;  4'd9:  b = 8'h37;  4'd10: b = 8'h31;  4'd11: b = 8'h39;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/usbcrr_front.sv
// Front end: takes a setup packet word and classifies it into a command.
// Depends on usbcrr_pkg.
`default_nettype none

module usbcrr_front (
    input  wire logic             i_push,
    input  wire usbcrr_pkg::t_req i_req,
    input  wire logic             i_q_full,
    output logic                  o_full,
    output logic                  o_cmd_push,
    output usbcrr_pkg::t_cmd      o_cmd
);
    import usbcrr_pkg::*;

    logic [31:0]      w0;
    logic [7:0]       want;
    logic [LEN_W-1:0] rom_len;
    logic             is_rom;

    assign w0   = i_req.request_word0;
    assign want = i_req.request_word1[15:8];

    assign o_full     = i_q_full;
    assign o_cmd_push = i_push && !i_q_full;

    // Request decode, first match wins
    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = OP_UNKNOWN;
        o_cmd.len       = SINGLE_LEN;
        o_cmd.ok_three  = (w0 == REQ_OK_THREE);
        o_cmd.key_set   = !i_req.request_word1[24];
        o_cmd.addr      = w0[14:8];
        o_cmd.keys[0]   = i_req.payload_word_a;
        o_cmd.keys[1]   = i_req.payload_word_b;
        o_cmd.keys[2]   = i_req.payload_word_c;
        o_cmd.keys[3]   = i_req.payload_word_d;
        o_cmd.storage   = i_req.storage_state_byte;
        o_cmd.cbw       = i_req.command_block_count;
        o_cmd.rx_status = i_req.receive_status_word;
        rom_len         = '0;
        is_rom          = 1'b0;

        if (w0 == REQ_GET_DEV_DESC) begin
            o_cmd.op  = OP_DEV_DESC;
            o_cmd.len = DEV_DESC_LEN;
        end else if (w0[31:16] == REQ_SET_ADDR_HI) begin
            o_cmd.op = OP_SET_ADDR;
        end else if (w0 == REQ_GET_CFG_DESC) begin
            o_cmd.op = OP_CFG_DESC;
            rom_len  = clamp_len(want, CFG_DESC_LEN);
            is_rom   = 1'b1;
        end else if (w0 == REQ_GET_LANG_DESC) begin
            o_cmd.op = OP_LANG_DESC;
            rom_len  = clamp_len(want, LANG_DESC_LEN);
            is_rom   = 1'b1;
        end else if (w0 == REQ_GET_STR_A || w0 == REQ_GET_STR_B) begin
            o_cmd.op = OP_STR_DESC;
            rom_len  = clamp_len(want, STR_DESC_LEN);
            is_rom   = 1'b1;
        end else if (w0[31:16] == REQ_SET_CFG_HI) begin
            o_cmd.op = OP_SET_CFG;
        end else if (w0 == REQ_VEND_ZERO) begin
            o_cmd.op = OP_VEND_ZERO;
        end else if (w0 == REQ_KEY_UPD) begin
            o_cmd.op = OP_KEY_UPD;
        end else if (w0 == REQ_STATUS) begin
            o_cmd.op  = OP_STATUS;
            o_cmd.len = STATUS_LEN;
        end else if (w0 == REQ_OK_TWO || w0 == REQ_OK_THREE) begin
            o_cmd.op  = OP_OK;
            o_cmd.len = OK_LEN;
        end

        // config, language and string descriptor reads: zero length gives a bare data end
        if (is_rom) begin
            if (rom_len == '0) begin
                o_cmd.op = OP_ZLP;
            end else begin
                o_cmd.len = rom_len;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/usbcrr_cmdq.sv
// Short command queue between the front and back ends.
// Depends on usbcrr_pkg.
`default_nettype none

module usbcrr_cmdq #(
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire usbcrr_pkg::t_cmd i_cmd,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output usbcrr_pkg::t_cmd      o_cmd
);
    import usbcrr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/usbcrr_back.sv
// Back end: runs one command, updates device state and key sets, and emits reply words.
// Depends on usbcrr_pkg.
`default_nettype none

module usbcrr_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_empty,
    input  wire usbcrr_pkg::t_cmd i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output usbcrr_pkg::t_rsp      o_rsp
);
    import usbcrr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_cmd             r_cmd;
    logic [LEN_W-1:0] r_idx;
    logic [6:0]       r_addr;
    logic             r_cfg;
    logic [31:0]      r_keys [8];
    logic             r_out_valid;
    t_rsp             r_rsp;

    logic             advance;
    logic             emit;
    logic             last;
    logic [LEN_W-1:0] key_off;
    logic [LEN_W-1:0] rx_off;
    logic [LEN_W-1:0] tag_off;
    t_reply_kind      kind;
    logic [7:0]       data;

    assign advance = !r_out_valid || i_pop;
    assign last    = (r_idx == r_cmd.len - LEN_W'(1));
    assign o_empty = !r_out_valid;
    assign o_rsp   = r_rsp;

    // Sequencer
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        emit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (advance) begin
                    emit = 1'b1;
                    if (last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Byte for the current position of the reply
    always_comb begin
        key_off = r_idx - STAT_KEY_BASE;
        rx_off  = r_idx - STAT_RX_BASE;
        tag_off = r_idx - LEN_W'(1);
        kind    = KIND_DATA;
        data    = 8'h00;
        unique case (r_cmd.op) inside
            OP_DEV_DESC:  data = dev_rom(r_idx[4:0]);
            OP_CFG_DESC:  data = cfg_rom(r_idx[4:0]);
            OP_LANG_DESC: data = lang_rom(r_idx[1:0]);
            OP_STR_DESC:  data = str_rom(r_idx[4:0]);
            OP_VEND_ZERO: data = 8'h00;
            OP_STATUS: begin
                if (r_idx == '0) begin
                    data = STATUS_HDR;
                end else if (r_idx <= STAT_TAG_END) begin
                    data = tag_rom(tag_off[3:0]);
                end else if (r_idx <= STAT_KEY_END) begin
                    data = word_byte(r_keys[key_off[4:2]], key_off[1:0]);
                end else if (r_idx == STAT_STORAGE) begin
                    data = r_cmd.storage;
                end else if (r_idx == STAT_CBW) begin
                    data = r_cmd.cbw;
                end else begin
                    data = word_byte(r_cmd.rx_status, rx_off[1:0]);
                end
            end
            OP_OK: begin
                case (r_idx[1:0])
                    2'd0:    data = OK_HDR;
                    2'd1:    data = r_cmd.ok_three ? OK_THREE : OK_TWO;
                    2'd2:    data = OK_CHAR_O;
                    default: data = OK_CHAR_K;
                endcase
            end
            OP_SET_ADDR, OP_SET_CFG: kind = KIND_ACK;
            OP_KEY_UPD, OP_ZLP:      kind = KIND_ZLP;
            default:                 kind = KIND_NONE;
        endcase
    end

    // Control state and device state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_cfg       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_keys[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                if (i_q_cmd.op == OP_SET_ADDR) begin
                    r_addr <= i_q_cmd.addr;
                end
                if (i_q_cmd.op == OP_SET_CFG) begin
                    r_cfg <= 1'b1;
                end
                if (i_q_cmd.op == OP_KEY_UPD) begin
                    for (int i = 0; i < 4; i++) begin
                        r_keys[{i_q_cmd.key_set, 2'(i)}] <= i_q_cmd.keys[i];
                    end
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command hold, position counter and output word
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            r_idx <= '0;
        end else if (emit) begin
            r_idx <= r_idx + LEN_W'(1);
        end
        if (emit) begin
            r_rsp.reply_kind     <= kind;
            r_rsp.reply_byte     <= (kind == KIND_DATA) ? data : 8'h00;
            r_rsp.last_of_reply  <= last;
            r_rsp.device_address <= r_addr;
            r_rsp.is_configured  <= r_cfg;
        end
    end

endmodule

`default_nettype wire

### rtl/usb_control_request_responder.sv
// Endpoint-zero control request responder, top level.
// A setup word's reply goes through the queue, the command load and the output register.
// The back end takes no new command before the last reply word of the current one is out;
// the status dump has 51 words, and emission stalls while a waiting word is not popped.
// Reset (synchronous, active low) clears the queue, sequencer, address, flag and key sets.
`default_nettype none

module usb_control_request_responder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire usbcrr_pkg::t_req i_req,
    output logic                  empty,
    input  wire logic             pop,
    output usbcrr_pkg::t_rsp      o_rsp
);
    import usbcrr_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // Classifier
    usbcrr_front u_front (
        .i_push     (push),
        .i_req      (i_req),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_cmd_push (q_push),
        .o_cmd      (front_cmd)
    );

    // Command queue
    usbcrr_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // Reply sequencer
    usbcrr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire

### rtl/usbcrr_checker.sv
// Port-level checks for the control request responder, bound to the top level.
// Depends on usbcrr_pkg and usb_control_request_responder.
`default_nettype none

module usbcrr_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_empty,
    input wire logic             i_pop,
    input wire usbcrr_pkg::t_rsp i_rsp
);
    import usbcrr_pkg::*;

    // A waiting reply word holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_rsp)))
        else $error("reply word changed while stalled");

    // Only data words carry a byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_rsp.reply_kind != KIND_DATA) |-> (i_rsp.reply_byte == 8'h00))
        else $error("non-data word carries a byte");

    // Data end, ack and no-reply words stand alone
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_rsp.reply_kind != KIND_DATA) |-> i_rsp.last_of_reply)
        else $error("non-data word not marked last");

    // Configured flag never clears between consecutive words
    a_cfg_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_pop && i_rsp.is_configured) |=> (i_empty || i_rsp.is_configured))
        else $error("configured flag cleared");

endmodule

bind usb_control_request_responder usbcrr_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_empty (empty),
    .i_pop   (pop),
    .i_rsp   (o_rsp)
);

`default_nettype wire

### bench/tb_usb_control_request_responder.sv
// Testbench for the endpoint-zero control request responder.
// A directed table, then random setup packets; reply words are checked by predictor or table.
// Depends on usbcrr_pkg and usb_control_request_responder.
`default_nettype none

module tb_usb_control_request_responder;
    import usbcrr_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 60;
    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;

    // Descriptor and tag bytes, first byte in the top byte lane
    localparam logic [18*8-1:0] DEV_BYTES =
        144'h1201_0002_0000_0040_0923_0606_0100_0102_0301;
    localparam logic [32*8-1:0] CFG_BYTES =
        256'h0902_2000_0101_0080_fa09_0400_0002_0806_5000_0705_0102_0002_0007_0582_0200_0200;
    localparam logic [4*8-1:0] LANG_BYTES = 32'h0403_0904;
    localparam logic [22*8-1:0] STR_BYTES =
        176'h1603_4800_4C00_4A00_5500_2000_5500_4400_4900_5300_4B00;
    localparam logic [12*8-1:0] TAG_BYTES = 96'h5151_3A32_3433_3630_3737_3139;

    typedef struct packed {
        t_req req;
        logic typed;
        t_rsp want;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_req i_req   = '0;
    logic full;
    logic empty;
    t_rsp o_rsp;

    // Predicted device state
    logic [6:0]  dev_addr;
    logic        dev_configured;
    logic [31:0] key_words [8];

    t_rsp      reply_words [$];
    t_rsp      replies_due [$];
    t_stim_row stim_table  [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit calm         = 1'b0;

    always #1 i_clk = ~i_clk;

    usb_control_request_responder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_rsp   (o_rsp)
    );

    // Byte idx of one of the fixed descriptors
    function automatic logic [7:0] desc_byte(input t_op which, input int idx);
        logic [7:0] b;
        case (which)
            OP_DEV_DESC:  b = DEV_BYTES[(17 - idx) * 8 +: 8];
            OP_CFG_DESC:  b = CFG_BYTES[(31 - idx) * 8 +: 8];
            OP_LANG_DESC: b = LANG_BYTES[(3 - idx) * 8 +: 8];
            default:      b = STR_BYTES[(21 - idx) * 8 +: 8];
        endcase
        return b;
    endfunction

    function automatic int desc_size(input t_op which);
        int n;
        case (which)
            OP_DEV_DESC:  n = 18;
            OP_CFG_DESC:  n = 32;
            OP_LANG_DESC: n = 4;
            default:      n = 22;
        endcase
        return n;
    endfunction

    // Append one reply word stamped with the current device state
    function automatic void add_reply(input t_reply_kind kind, input logic [7:0] b);
        t_rsp w;
        w.reply_kind     = kind;
        w.reply_byte     = (kind == KIND_DATA) ? b : 8'h00;
        w.last_of_reply  = 1'b0;
        w.device_address = dev_addr;
        w.is_configured  = dev_configured;
        reply_words.push_back(w);
    endfunction

    function automatic void add_word_bytes(input logic [31:0] w);
        int j;
        for (j = 0; j < 4; j++) begin
            add_reply(KIND_DATA, w[31 - 8 * j -: 8]);
        end
    endfunction

    // Work out the reply words of one setup packet into reply_words
    function automatic void answer_request(input t_req r);
        logic [31:0] w0;
        logic [7:0]  asked;
        t_op         which;
        int          count;
        int          i;
        int          base;
        t_rsp        tail;
        w0    = r.request_word0;
        asked = r.request_word1[15:8];
        which = OP_UNKNOWN;
        reply_words.delete();
        if (w0 == REQ_GET_DEV_DESC) begin
            which = OP_DEV_DESC;
            asked = 8'hFF;
        end else if (w0[31:16] == REQ_SET_ADDR_HI) begin
            dev_addr = w0[14:8];
            add_reply(KIND_ACK, 8'h00);
        end else if (w0 == REQ_GET_CFG_DESC) begin
            which = OP_CFG_DESC;
        end else if (w0 == REQ_GET_LANG_DESC) begin
            which = OP_LANG_DESC;
        end else if (w0 == REQ_GET_STR_A || w0 == REQ_GET_STR_B) begin
            which = OP_STR_DESC;
        end else if (w0[31:16] == REQ_SET_CFG_HI) begin
            dev_configured = 1'b1;
            add_reply(KIND_ACK, 8'h00);
        end else if (w0 == REQ_VEND_ZERO) begin
            add_reply(KIND_DATA, 8'h00);
        end else if (w0 == REQ_KEY_UPD) begin
            // odd byte 0 of word 1 picks set 0
            base = r.request_word1[24] ? 0 : 4;
            key_words[base]     = r.payload_word_a;
            key_words[base + 1] = r.payload_word_b;
            key_words[base + 2] = r.payload_word_c;
            key_words[base + 3] = r.payload_word_d;
            add_reply(KIND_ZLP, 8'h00);
        end else if (w0 == REQ_STATUS) begin
            // header, tag, both key sets, storage state, block count, rx status
            add_reply(KIND_DATA, 8'hFA);
            for (i = 0; i < 12; i++) begin
                add_reply(KIND_DATA, TAG_BYTES[(11 - i) * 8 +: 8]);
            end
            for (i = 0; i < 8; i++) begin
                add_word_bytes(key_words[i]);
            end
            add_reply(KIND_DATA, r.storage_state_byte);
            add_reply(KIND_DATA, r.command_block_count);
            add_word_bytes(r.receive_status_word);
        end else if (w0 == REQ_OK_TWO || w0 == REQ_OK_THREE) begin
            add_reply(KIND_DATA, 8'hFB);
            add_reply(KIND_DATA, (w0 == REQ_OK_TWO) ? 8'h02 : 8'h03);
            add_reply(KIND_DATA, 8'h4F);
            add_reply(KIND_DATA, 8'h6B);
        end else begin
            add_reply(KIND_NONE, 8'h00);
        end

        // descriptors: length clamped to the descriptor size, zero gives a ZLP
        if (which != OP_UNKNOWN) begin
            count = (int'(asked) > desc_size(which)) ? desc_size(which) : int'(asked);
            if (count == 0) begin
                add_reply(KIND_ZLP, 8'h00);
            end
            for (i = 0; i < count; i++) begin
                add_reply(KIND_DATA, desc_byte(which, i));
            end
        end

        tail = reply_words.pop_back();
        tail.last_of_reply = 1'b1;
        reply_words.push_back(tail);
    endfunction

    // One table row; payload and operands derived from fill
    function automatic void add_row(input logic [31:0] w0, input logic [31:0] w1,
                                    input logic [31:0] fill, input logic typed,
                                    input t_reply_kind kind, input logic [6:0] addr,
                                    input logic cfg);
        t_stim_row row;
        row.req.request_word0       = w0;
        row.req.request_word1       = w1;
        row.req.payload_word_a      = fill;
        row.req.payload_word_b      = ~fill;
        row.req.payload_word_c      = {fill[15:0], fill[31:16]};
        row.req.payload_word_d      = fill ^ 32'h5A5A_A5A5;
        row.req.storage_state_byte  = fill[7:0];
        row.req.command_block_count = fill[15:8];
        row.req.receive_status_word = ~fill;
        row.typed                   = typed;
        row.want.reply_kind         = kind;
        row.want.reply_byte         = 8'h00;
        row.want.last_of_reply      = 1'b1;
        row.want.device_address     = addr;
        row.want.is_configured      = cfg;
        stim_table.push_back(row);
    endfunction

    function automatic void load_table();
        // unknown requests straight after reset, then a device descriptor
        add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_NONE, 7'd0, 1'b0);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_GET_DEV_DESC, 32'h0000_0000, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        // descriptor lengths: zero, above, at and below the size
        add_row(REQ_GET_CFG_DESC, 32'hFFFF_00FF, 32'h0000_0000, 1'b1, KIND_ZLP, 7'd0, 1'b0);
        add_row(REQ_GET_CFG_DESC, 32'h0000_FF00, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_GET_CFG_DESC, 32'h0000_2000, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_GET_LANG_DESC, 32'h0000_0300, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_GET_LANG_DESC, 32'h0000_FF00, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_GET_STR_A, 32'h0000_1600, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_GET_STR_B, 32'h0000_1700, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_GET_STR_A, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_ZLP, 7'd0, 1'b0);
        // address: value high byte masked to 7 bits, value low byte ignored
        add_row({REQ_SET_ADDR_HI, 16'hFF00}, 32'h0, 32'h0, 1'b1, KIND_ACK, 7'h7F, 1'b0);
        add_row({REQ_SET_ADDR_HI, 16'h00FF}, 32'h0, 32'h0, 1'b1, KIND_ACK, 7'h00, 1'b0);
        add_row({REQ_SET_ADDR_HI, 16'h2A00}, 32'h0, 32'h0, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_VEND_ZERO, 32'h0000_0000, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        // key sets: odd then even selector byte
        add_row(REQ_KEY_UPD, 32'h0100_0000, 32'hFFFF_FFFF, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_KEY_UPD, 32'hFE00_0000, 32'h1234_5678, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_STATUS, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_OK_TWO, 32'h0000_0000, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_OK_THREE, 32'h0000_0000, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row({REQ_SET_CFG_HI, 16'hFFFF}, 32'h0, 32'h0, 1'b0, KIND_NONE, 7'd0, 1'b0);
        // a near-miss descriptor code, two requests one bit off a known one, then a status dump
        add_row(32'h8006_0004, 32'h0000_FF00, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(32'hC001_0001, 32'h0000_0000, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(32'h0A0B_0C0C, 32'h0100_0000, 32'hFFFF_FFFF, 1'b0, KIND_NONE, 7'd0, 1'b0);
        add_row(REQ_STATUS, 32'h0000_0000, 32'h0000_0000, 1'b0, KIND_NONE, 7'd0, 1'b0);
    endfunction

    // Mostly well-formed requests with random content, some noise and near misses
    function automatic t_req random_request();
        t_req        r;
        int          pick;
        logic [31:0] code;
        r.request_word0       = $urandom();
        r.request_word1       = $urandom();
        r.payload_word_a      = $urandom();
        r.payload_word_b      = $urandom();
        r.payload_word_c      = $urandom();
        r.payload_word_d      = $urandom();
        r.storage_state_byte  = 8'($urandom_range(0, 255));
        r.command_block_count = 8'($urandom_range(0, 255));
        r.receive_status_word = $urandom();
        // requested length biased to zero, the edges and small values
        case ($urandom_range(0, 3))
            0:       r.request_word1[15:8] = 8'h00;
            1:       r.request_word1[15:8] = 8'($urandom_range(1, 40));
            2:       r.request_word1[15:8] = 8'hFF;
            default: r.request_word1[15:8] = 8'($urandom_range(0, 255));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            r.request_word0 = REQ_GET_DEV_DESC;
        end else if (pick < 18) begin
            r.request_word0 = REQ_GET_CFG_DESC;
        end else if (pick < 26) begin
            r.request_word0 = REQ_GET_LANG_DESC;
        end else if (pick < 34) begin
            r.request_word0 = REQ_GET_STR_A;
        end else if (pick < 40) begin
            r.request_word0 = REQ_GET_STR_B;
        end else if (pick < 48) begin
            r.request_word0 = {REQ_SET_ADDR_HI, 16'($urandom_range(0, 65535))};
        end else if (pick < 53) begin
            r.request_word0 = {REQ_SET_CFG_HI, 16'($urandom_range(0, 65535))};
        end else if (pick < 59) begin
            r.request_word0 = REQ_VEND_ZERO;
        end else if (pick < 73) begin
            r.request_word0 = REQ_KEY_UPD;
        end else if (pick < 79) begin
            r.request_word0 = REQ_STATUS;
        end else if (pick < 85) begin
            r.request_word0 = REQ_OK_TWO;
        end else if (pick < 90) begin
            r.request_word0 = REQ_OK_THREE;
        end else if (pick < 96) begin
            case ($urandom_range(0, 5))
                0:       code = REQ_GET_DEV_DESC;
                1:       code = REQ_GET_CFG_DESC;
                2:       code = REQ_GET_STR_A;
                3:       code = REQ_KEY_UPD;
                4:       code = REQ_STATUS;
                default: code = REQ_OK_THREE;
            endcase
            r.request_word0 = code ^ (32'h1 << $urandom_range(0, 31));
        end
        return r;
    endfunction

    task automatic send_request(input t_req r, input logic typed, input t_rsp want);
        int gap;
        int k;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        answer_request(r);
        if (typed) begin
            replies_due.push_back(want);
        end else begin
            for (k = 0; k < reply_words.size(); k++) begin
                replies_due.push_back(reply_words[k]);
            end
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    // Reply side: compare each popped word, then drive pop with stall bursts
    always @(posedge i_clk) begin
        t_rsp exp_word;
        if (i_rst_n && pop && !empty) begin
            if (replies_due.size() == 0) begin
                $error("unexpected reply word: kind %0d byte 0x%0h",
                       o_rsp.reply_kind, o_rsp.reply_byte);
                mismatches++;
            end else begin
                exp_word = replies_due.pop_front();
                check_field("reply_kind", 8'(exp_word.reply_kind),
                            8'(o_rsp.reply_kind));
                check_field("reply_byte", exp_word.reply_byte, o_rsp.reply_byte);
                check_field("last_of_reply", 8'(exp_word.last_of_reply),
                            8'(o_rsp.last_of_reply));
                check_field("device_address", 8'(exp_word.device_address),
                            8'(o_rsp.device_address));
                check_field("is_configured", 8'(exp_word.is_configured),
                            8'(o_rsp.is_configured));
            end
        end
        if (stall_left > 0 && !calm) begin
            stall_left = stall_left - 1;
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Watchdog: too long with nothing moving on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_usb_control_request_responder: errors");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int n;
        dev_addr       = 7'd0;
        dev_configured = 1'b0;
        for (n = 0; n < 8; n++) begin
            key_words[n] = 32'h0;
        end
        load_table();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < stim_table.size(); n++) begin
            send_request(stim_table[n].req, stim_table[n].typed, stim_table[n].want);
        end
        // hold off until every reply has come back
        wait_drained();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            send_request(random_request(), 1'b0, '0);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            $error("%0d reply words never arrived", replies_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb_usb_control_request_responder: clean");
        end else begin
            $display("tb_usb_control_request_responder: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
